@@ design/complex_arithmetic_unit_macros.svh @@
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cau check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cau check failed");

`endif

@@ design/cau_pkg.sv @@
package cau_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned DIV_STEPS       = 33;
  localparam int unsigned SQRT_STEPS      = 32;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned ITER_STAGES     =
    (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef enum logic [2:0] {
    OP_EQ  = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_MAG = 3'd5
  } cau_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } cau_status_e;

  // per-item data that rides along the iteration stages untouched
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] fix_re;
    logic [31:0] fix_im;
    logic        fix_sat;
    logic        eq;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic        div0;
  } cau_side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] quo;
    logic [32:0] tail;
  } cau_div_lane_t;

  typedef struct packed {
    cau_div_lane_t re;
    cau_div_lane_t im;
    logic [63:0]   den;
    logic [63:0]   sq_src;
    logic [33:0]   sq_rem;
    logic [31:0]   sq_root;
    cau_side_t     side;
  } cau_iter_t;

  // saturate sign and magnitude to 32-bit two's complement, flag in msb
  function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] v;
    logic        f;
    f = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        v = 32'h8000_0000;
        f = 1'b1;
      end else begin
        v = 32'(64'd0 - mag);
      end
    end else if (mag > 64'h7FFF_FFFF) begin
      v = 32'h7FFF_FFFF;
      f = 1'b1;
    end else begin
      v = mag[31:0];
    end
    return {f, v};
  endfunction

endpackage

@@ design/cau_iter_stage.sv @@
module cau_iter_stage import cau_pkg::*; #(
  parameter int unsigned FirstStep = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cau_iter_t data_i,
  output logic      valid_o,
  output cau_iter_t data_o
);

  logic      valid_q;
  cau_iter_t data_q;
  cau_iter_t data_d;

  // one restoring division step
  function automatic cau_div_lane_t div_step(input cau_div_lane_t l,
                                             input logic [63:0] den);
    logic [64:0]   r;
    cau_div_lane_t o;
    o      = l;
    r      = {l.rem, l.tail[32]};
    o.tail = {l.tail[31:0], 1'b0};
    if (r >= {1'b0, den}) begin
      r     = r - {1'b0, den};
      o.quo = {l.quo[31:0], 1'b1};
    end else begin
      o.quo = {l.quo[31:0], 1'b0};
    end
    o.rem = r[63:0];
    return o;
  endfunction

  always_comb begin
    logic [35:0] r2;
    logic [35:0] tr;
    data_d = data_i;
    r2     = '0;
    tr     = '0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      if (FirstStep + s < DIV_STEPS) begin
        data_d.re = div_step(data_d.re, data_d.den);
        data_d.im = div_step(data_d.im, data_d.den);
      end
      if (FirstStep + s < SQRT_STEPS) begin
        // digit-by-digit square root, two radicand bits per step
        r2 = {data_d.sq_rem, data_d.sq_src[63:62]};
        tr = {2'b00, data_d.sq_root, 2'b01};
        data_d.sq_src = {data_d.sq_src[61:0], 2'b00};
        if (r2 >= tr) begin
          r2 = r2 - tr;
          data_d.sq_root = {data_d.sq_root[30:0], 1'b1};
        end else begin
          data_d.sq_root = {data_d.sq_root[30:0], 1'b0};
        end
        data_d.sq_rem = r2[33:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/complex_arithmetic_unit.sv @@
// complex arithmetic unit, signed fixed point, one item per cycle when not stalled
// registers: stages b-e, ITER_STAGES iteration stages (17 by default), output
// throughput: one item per cycle when not stalled; the shared divide/root chain
// of 2 steps per stage sets the depth, the 32x32 multipliers set the stage width
// reset: rst_ni asynchronous, clears every stage valid bit, payload not reset
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] a_real_i,
  input  logic signed [31:0] a_imag_i,
  input  logic signed [31:0] b_real_i,
  input  logic signed [31:0] b_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_real_o,
  output logic signed [31:0] res_imag_o,
  output logic               is_equal_o,
  output logic [1:0]         status_o
);

  localparam int unsigned HiShift = DIV_STEPS - FracBits;
  localparam logic [64:0] RoundHalf = 65'(1) << (FracBits - 1);

  // whole pipeline moves together unless a finished item is held at the output
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------
  // stage b: the six products, operands muxed so magnitude reuses them
  // ---------------------------------------------------------------------
  logic               vb_q;
  logic [2:0]         func_b_q;
  logic signed [31:0] ar_b_q, ai_b_q, br_b_q, bi_b_q;
  logic signed [63:0] p0_b_q, p1_b_q, p2_b_q, p3_b_q, pbr_b_q, pbi_b_q;
  logic signed [31:0] mul_y0, mul_y1;
  logic               is_mag;

  assign is_mag = (func_i == OP_MAG);
  assign mul_y0 = is_mag ? a_real_i : b_real_i;
  assign mul_y1 = is_mag ? a_imag_i : b_imag_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_b_q <= func_i;
      ar_b_q   <= a_real_i;
      ai_b_q   <= a_imag_i;
      br_b_q   <= b_real_i;
      bi_b_q   <= b_imag_i;
      p0_b_q   <= 64'(a_real_i) * 64'(mul_y0);
      p1_b_q   <= 64'(a_imag_i) * 64'(mul_y1);
      p2_b_q   <= 64'(a_real_i) * 64'(b_imag_i);
      p3_b_q   <= 64'(a_imag_i) * 64'(b_real_i);
      pbr_b_q  <= 64'(b_real_i) * 64'(b_real_i);
      pbi_b_q  <= 64'(b_imag_i) * 64'(b_imag_i);
    end
  end

  // ---------------------------------------------------------------------
  // stage c: product sums, squared magnitudes, add and subtract results
  // ---------------------------------------------------------------------
  logic               vc_q;
  logic signed [64:0] sum_re_c_q, sum_im_c_q;
  logic [63:0]        s_c_q, den_c_q;
  cau_side_t          side_c_q;

  logic signed [64:0] sum_re_d, sum_im_d;
  logic signed [32:0] as_re, as_im;
  logic [32:0]        as_re_mag, as_im_mag;
  logic [32:0]        as_re_sat, as_im_sat;
  cau_side_t          side_c_d;

  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    as_re    = '0;
    as_im    = '0;
    unique case (cau_op_e'(func_b_q))
      OP_ADD: begin
        as_re = 33'(ar_b_q) + 33'(br_b_q);
        as_im = 33'(ai_b_q) + 33'(bi_b_q);
      end
      OP_SUB: begin
        as_re = 33'(ar_b_q) - 33'(br_b_q);
        as_im = 33'(ai_b_q) - 33'(bi_b_q);
      end
      OP_MUL: begin
        sum_re_d = 65'(p0_b_q) - 65'(p1_b_q);
        sum_im_d = 65'(p2_b_q) + 65'(p3_b_q);
      end
      OP_DIV: begin
        // a times conj(b)
        sum_re_d = 65'(p0_b_q) + 65'(p1_b_q);
        sum_im_d = 65'(p3_b_q) - 65'(p2_b_q);
      end
      default: begin
      end
    endcase
    as_re_mag = as_re[32] ? 33'(-as_re) : as_re;
    as_im_mag = as_im[32] ? 33'(-as_im) : as_im;
    as_re_sat = sat32(as_re[32], 64'(as_re_mag));
    as_im_sat = sat32(as_im[32], 64'(as_im_mag));

    side_c_d         = '0;
    side_c_d.func    = func_b_q;
    side_c_d.eq      = (ar_b_q == br_b_q) && (ai_b_q == bi_b_q);
    side_c_d.fix_re  = as_re_sat[31:0];
    side_c_d.fix_im  = as_im_sat[31:0];
    side_c_d.fix_sat = as_re_sat[32] || as_im_sat[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_re_c_q <= sum_re_d;
      sum_im_c_q <= sum_im_d;
      // both squares are non-negative, sum stays below 2^64
      s_c_q      <= 64'(p0_b_q) + 64'(p1_b_q);
      den_c_q    <= 64'(pbr_b_q) + 64'(pbi_b_q);
      side_c_q   <= side_c_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage d: sign and magnitude of the product sums, zero divisor check
  // ---------------------------------------------------------------------
  logic        vd_q;
  logic [63:0] mag_re_d_q, mag_im_d_q, s_d_q, den_d_q;
  cau_side_t   side_d_q;
  cau_side_t   side_d_d;

  always_comb begin
    side_d_d        = side_c_q;
    side_d_d.neg_re = sum_re_c_q[64];
    side_d_d.neg_im = sum_im_c_q[64];
    side_d_d.div0   = (den_c_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_re_d_q <= sum_re_c_q[64] ? 64'(-sum_re_c_q) : sum_re_c_q[63:0];
      mag_im_d_q <= sum_im_c_q[64] ? 64'(-sum_im_c_q) : sum_im_c_q[63:0];
      s_d_q      <= s_c_q;
      den_d_q    <= den_c_q;
      side_d_q   <= side_d_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage e: multiply rounding, quotient overflow test, iteration setup
  // ---------------------------------------------------------------------
  logic [ITER_STAGES:0] iter_valid;
  cau_iter_t            iter_data [ITER_STAGES+1];

  logic        ve_q;
  cau_iter_t   iter_e_q;
  cau_iter_t   iter_e_d;
  logic [63:0] hi_re, hi_im;
  logic [64:0] mr_re, mr_im;
  logic [32:0] mul_re_sat, mul_im_sat;

  always_comb begin
    // quotient bits above bit 32 only come from the high part of the dividend
    hi_re = mag_re_d_q >> HiShift;
    hi_im = mag_im_d_q >> HiShift;
    mr_re = (65'(mag_re_d_q) + RoundHalf) >> FracBits;
    mr_im = (65'(mag_im_d_q) + RoundHalf) >> FracBits;
    mul_re_sat = sat32(side_d_q.neg_re, mr_re[63:0]);
    mul_im_sat = sat32(side_d_q.neg_im, mr_im[63:0]);

    iter_e_d         = '0;
    iter_e_d.side    = side_d_q;
    iter_e_d.re.rem  = hi_re;
    iter_e_d.re.tail = 33'(mag_re_d_q << FracBits);
    iter_e_d.im.rem  = hi_im;
    iter_e_d.im.tail = 33'(mag_im_d_q << FracBits);
    iter_e_d.den     = den_d_q;
    iter_e_d.sq_src  = s_d_q;
    iter_e_d.side.ovf_re = (hi_re >= den_d_q);
    iter_e_d.side.ovf_im = (hi_im >= den_d_q);
    if (side_d_q.func == OP_MUL) begin
      iter_e_d.side.fix_re  = mul_re_sat[31:0];
      iter_e_d.side.fix_im  = mul_im_sat[31:0];
      iter_e_d.side.fix_sat = mul_re_sat[32] || mul_im_sat[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      iter_e_q <= iter_e_d;
    end
  end

  assign iter_valid[0] = ve_q;
  assign iter_data[0]  = iter_e_q;

  // shared chain: both quotient lanes and the square root advance together
  for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
    cau_iter_stage #(
      .FirstStep(g * STEPS_PER_STAGE)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(iter_valid[g]),
      .data_i (iter_data[g]),
      .valid_o(iter_valid[g+1]),
      .data_o (iter_data[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // final stage: round quotients and root, pick the result, output register
  // ---------------------------------------------------------------------
  cau_iter_t   fin;
  logic [33:0] q_re, q_im;
  logic [32:0] root_r;
  logic [32:0] div_re_sat, div_im_sat, mag_sat;

  logic               out_valid_q;
  logic signed [31:0] res_re_q, res_im_q;
  logic               eq_q;
  cau_status_e        status_q;
  logic signed [31:0] res_re_d, res_im_d;
  logic               eq_d;
  cau_status_e        status_d;

  always_comb begin
    fin  = iter_data[ITER_STAGES];
    // round half away from zero: remainder at least half the divisor
    q_re = 34'(fin.re.quo) + 34'({fin.re.rem, 1'b0} >= {1'b0, fin.den});
    q_im = 34'(fin.im.quo) + 34'({fin.im.rem, 1'b0} >= {1'b0, fin.den});
    root_r = 33'(fin.sq_root) + 33'(fin.sq_rem > 34'(fin.sq_root));
    div_re_sat = sat32(fin.side.neg_re,
                       fin.side.ovf_re ? 64'h1_0000_0000 : 64'(q_re));
    div_im_sat = sat32(fin.side.neg_im,
                       fin.side.ovf_im ? 64'h1_0000_0000 : 64'(q_im));
    mag_sat = sat32(1'b0, 64'(root_r));

    res_re_d = '0;
    res_im_d = '0;
    eq_d     = 1'b0;
    status_d = ST_OK;
    unique case (cau_op_e'(fin.side.func))
      OP_EQ: begin
        eq_d = fin.side.eq;
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        res_re_d = fin.side.fix_re;
        res_im_d = fin.side.fix_im;
        status_d = fin.side.fix_sat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (fin.side.div0) begin
          status_d = ST_DIV0;
        end else begin
          res_re_d = div_re_sat[31:0];
          res_im_d = div_im_sat[31:0];
          status_d = (div_re_sat[32] || div_im_sat[32]) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        res_re_d = mag_sat[31:0];
        status_d = mag_sat[32] ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= iter_valid[ITER_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      eq_q     <= eq_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_real_o  = res_re_q;
  assign res_imag_o  = res_im_q;
  assign is_equal_o  = eq_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `CAU_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `CAU_ASSERT_NEXT(a_chain_hold, in_stall_o, $stable(iter_valid))
  `CAU_ASSERT_IMPL(a_div0_zero, out_valid_o && status_o == ST_DIV0, res_real_o == '0 && res_imag_o == '0)
  `CAU_ASSERT_IMPL(a_eq_only, out_valid_o && is_equal_o, res_real_o == '0 && res_imag_o == '0 && status_o == ST_OK)

endmodule
